FILE: rtl/cursor_line_edit_buffer_macros.svh
// assertion macros shared by the line edit buffer rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef CURSOR_LINE_EDIT_BUFFER_MACROS_SVH
`define CURSOR_LINE_EDIT_BUFFER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CLEB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CLEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cleb_pkg.sv
// shared types and constants for the line edit buffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cleb_pkg;

  localparam int BYTE_W         = 8;
  localparam int IDX_W          = 6;
  localparam int NODE_DEPTH     = 64;
  localparam int POOL_SLOTS_DEF = 63;

  localparam logic [BYTE_W-1:0] KEY_HOME    = 8'h5B;
  localparam logic [BYTE_W-1:0] KEY_END     = 8'h5D;
  localparam logic [BYTE_W-1:0] KEY_BACK    = 8'h3C;
  localparam logic [BYTE_W-1:0] KEY_NEWLINE = 8'h0A;

  typedef logic [2:0] key_class_t;
  localparam key_class_t KC_INS  = 3'd0;
  localparam key_class_t KC_HOME = 3'd1;
  localparam key_class_t KC_END  = 3'd2;
  localparam key_class_t KC_BACK = 3'd3;
  localparam key_class_t KC_NL   = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_prev_cur;
    logic rd_free_top;
    logic ins_link1;
    logic ins_link2;
    logic rd_prev_victim;
    logic del_link;
    logic rd_next_head;
    logic set_cursor_home;
    logic set_cursor_end;
    logic set_ovf;
    logic walk_start;
    logic walk_rd;
    logic walk_emit;
    logic emit_final;
    logic clear_line;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    key_class_t key;
    logic       fc_zero;
    logic       victim_zero;
    logic       walk_done;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/cleb_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cleb_ctrl.sv
// sequencer for the line edit buffer: one state per memory step of each key
// depends on cleb_pkg and the assertion macros header
`timescale 1ns / 1ps
`default_nettype none
`include "cursor_line_edit_buffer_macros.svh"

module cleb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cleb_pkg::sts_t sts,
  output cleb_pkg::cmd_t     cmd
);
  import cleb_pkg::*;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_INS_B   = 4'd2;
  localparam logic [3:0] S_INS_C   = 4'd3;
  localparam logic [3:0] S_DEL_B   = 4'd4;
  localparam logic [3:0] S_DEL_C   = 4'd5;
  localparam logic [3:0] S_HOME    = 4'd6;
  localparam logic [3:0] S_NL_HEAD = 4'd7;
  localparam logic [3:0] S_WALK_RD = 4'd8;
  localparam logic [3:0] S_WALK_WR = 4'd9;
  localparam logic [3:0] S_FINAL   = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        // put the head links back on the head
        cmd.clear_line = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (sts.key)
            KC_INS: begin
              if (sts.fc_zero) begin
                cmd.set_ovf = 1'b1;
              end else begin
                cmd.rd_prev_cur = 1'b1;
                cmd.rd_free_top = 1'b1;
                state_nxt       = S_INS_B;
              end
            end
            KC_HOME: begin
              cmd.rd_next_head = 1'b1;
              state_nxt        = S_HOME;
            end
            KC_END: begin
              cmd.set_cursor_end = 1'b1;
            end
            KC_BACK: begin
              cmd.rd_prev_cur = 1'b1;
              state_nxt       = S_DEL_B;
            end
            KC_NL: begin
              cmd.rd_next_head = 1'b1;
              state_nxt        = S_NL_HEAD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS_B: begin
        cmd.ins_link1 = 1'b1;
        state_nxt     = S_INS_C;
      end
      S_INS_C: begin
        cmd.ins_link2 = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_DEL_B: begin
        // cursor at the start of the line: nothing to erase
        if (sts.victim_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_prev_victim = 1'b1;
          state_nxt          = S_DEL_C;
        end
      end
      S_DEL_C: begin
        cmd.del_link = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_HOME: begin
        cmd.set_cursor_home = 1'b1;
        state_nxt           = S_IDLE;
      end
      S_NL_HEAD: begin
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (sts.walk_done) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WALK_WR;
        end
      end
      S_WALK_WR: begin
        // read data holds in the rams until the output slot frees up
        if (sts.out_free) begin
          cmd.walk_emit = 1'b1;
          state_nxt     = S_WALK_RD;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          cmd.clear_line = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CLEB_ASSERT_NOW(a_emit_needs_free, cmd.walk_emit || cmd.emit_final, sts.out_free, "output busy")
  `CLEB_ASSERT_NOW(a_insert_has_slot, cmd.ins_link1, !sts.fc_zero, "insert with empty free stack")
  `CLEB_ASSERT_NEXT(a_insert_completes, cmd.ins_link1, cmd.ins_link2, "insert step missing")

endmodule

`default_nettype wire

FILE: rtl/cleb_dpath.sv
// datapath: link, character and free-stack rams, cursor, counters, output register
// depends on cleb_pkg, cleb_ram and the assertion macros header
`timescale 1ns / 1ps
`default_nettype none
`include "cursor_line_edit_buffer_macros.svh"

module cleb_dpath #(
  parameter int POOL_SLOTS = cleb_pkg::POOL_SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [cleb_pkg::BYTE_W-1:0] in_byte,
  output logic      [cleb_pkg::BYTE_W-1:0] out_byte,
  output logic                             out_last,
  output logic                             out_dropped,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  input  wire cleb_pkg::cmd_t              cmd,
  output cleb_pkg::sts_t                   sts
);
  import cleb_pkg::*;

  localparam int FREE_AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [IDX_W-1:0] POOL_N = IDX_W'(POOL_SLOTS);

  logic [BYTE_W-1:0] byte_r;
  logic [IDX_W-1:0]  cursor_r, fc_r, lw_r, slot_r, victim_r, node_r, steps_r;
  logic              ovf_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r, out_dropped_r, out_valid_r;

  logic [IDX_W-1:0]  next_rd, prev_rd, free_rd, slot_w;
  logic [BYTE_W-1:0] char_rd;

  logic               nxt_we, prv_we, nxt_re, prv_re;
  logic [IDX_W-1:0]   nxt_waddr, nxt_wdata, nxt_raddr;
  logic [IDX_W-1:0]   prv_waddr, prv_wdata, prv_raddr;
  logic               free_we;
  logic [FREE_AW-1:0] free_waddr, free_raddr;
  logic               out_free;

  // free stack entries below the low-water mark still hold their refill value
  assign slot_w     = (fc_r <= lw_r) ? fc_r : free_rd;
  assign free_raddr = FREE_AW'(fc_r - 1'b1);
  assign free_waddr = FREE_AW'(fc_r);
  assign free_we    = cmd.del_link && (fc_r < POOL_N);
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    sts.fc_zero     = (fc_r == '0);
    sts.victim_zero = (prev_rd == '0);
    sts.walk_done   = (node_r == '0) || (steps_r == POOL_N);
    sts.out_free    = out_free;
    if (in_byte == KEY_NEWLINE) begin
      sts.key = KC_NL;
    end else if (in_byte == KEY_END) begin
      sts.key = KC_END;
    end else if (in_byte == KEY_HOME) begin
      sts.key = KC_HOME;
    end else if (in_byte == KEY_BACK) begin
      sts.key = KC_BACK;
    end else begin
      sts.key = KC_INS;
    end
  end

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = '0;
    nxt_wdata = '0;
    prv_we    = 1'b0;
    prv_waddr = '0;
    prv_wdata = '0;
    unique if (cmd.ins_link1) begin
      nxt_we    = 1'b1;
      nxt_waddr = prev_rd;
      nxt_wdata = slot_w;
      prv_we    = 1'b1;
      prv_waddr = slot_w;
      prv_wdata = prev_rd;
    end else if (cmd.ins_link2) begin
      nxt_we    = 1'b1;
      nxt_waddr = slot_r;
      nxt_wdata = cursor_r;
      prv_we    = 1'b1;
      prv_waddr = cursor_r;
      prv_wdata = slot_r;
    end else if (cmd.del_link) begin
      nxt_we    = 1'b1;
      nxt_waddr = prev_rd;
      nxt_wdata = cursor_r;
      prv_we    = 1'b1;
      prv_waddr = cursor_r;
      prv_wdata = prev_rd;
    end else if (cmd.clear_line) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else begin
      nxt_we = 1'b0;
    end
  end

  assign nxt_re    = cmd.rd_next_head || cmd.walk_rd;
  assign nxt_raddr = cmd.walk_rd ? node_r : '0;
  assign prv_re    = cmd.rd_prev_cur || cmd.rd_prev_victim;
  assign prv_raddr = cmd.rd_prev_victim ? prev_rd : cursor_r;

  cleb_ram #(.WIDTH(IDX_W), .DEPTH(NODE_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .re    (nxt_re),
    .raddr (nxt_raddr),
    .rdata (next_rd)
  );

  cleb_ram #(.WIDTH(IDX_W), .DEPTH(NODE_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .re    (prv_re),
    .raddr (prv_raddr),
    .rdata (prev_rd)
  );

  cleb_ram #(.WIDTH(BYTE_W), .DEPTH(NODE_DEPTH)) u_char_ram (
    .clk   (clk),
    .we    (cmd.ins_link1),
    .waddr (slot_w),
    .wdata (byte_r),
    .re    (cmd.walk_rd),
    .raddr (node_r),
    .rdata (char_rd)
  );

  cleb_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (victim_r),
    .re    (cmd.rd_free_top),
    .raddr (free_raddr),
    .rdata (free_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      fc_r        <= POOL_N;
      lw_r        <= POOL_N;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_line) begin
        cursor_r <= '0;
        fc_r     <= POOL_N;
        lw_r     <= POOL_N;
        ovf_r    <= 1'b0;
      end else begin
        if (cmd.set_cursor_end) begin
          cursor_r <= '0;
        end else if (cmd.set_cursor_home) begin
          cursor_r <= next_rd;
        end
        if (cmd.set_ovf) begin
          ovf_r <= 1'b1;
        end
        if (cmd.ins_link1) begin
          fc_r <= fc_r - 1'b1;
          if (fc_r <= lw_r) begin
            lw_r <= fc_r - 1'b1;
          end
        end else if (free_we) begin
          fc_r <= fc_r + 1'b1;
        end
      end
      if (cmd.walk_emit || cmd.emit_final) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
    end
    if (cmd.ins_link1) begin
      slot_r <= slot_w;
    end
    if (cmd.rd_prev_victim) begin
      victim_r <= prev_rd;
    end
    if (cmd.walk_start) begin
      node_r  <= next_rd;
      steps_r <= '0;
    end else if (cmd.walk_emit) begin
      node_r  <= next_rd;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.walk_emit) begin
      out_byte_r    <= char_rd;
      out_last_r    <= 1'b0;
      out_dropped_r <= 1'b0;
    end else if (cmd.emit_final) begin
      out_byte_r    <= KEY_NEWLINE;
      out_last_r    <= 1'b1;
      out_dropped_r <= ovf_r;
    end
  end

  assign out_byte    = out_byte_r;
  assign out_last    = out_last_r;
  assign out_dropped = out_dropped_r;
  assign out_valid   = out_valid_r;

  `CLEB_ASSERT_NOW(a_lw_below_count, 1'b1, lw_r <= fc_r, "low-water mark above free count")
  `CLEB_ASSERT_NOW(a_count_in_pool, 1'b1, fc_r <= POOL_N, "free count above pool size")

endmodule

`default_nettype wire

FILE: rtl/cursor_line_edit_buffer.sv
// Line edit buffer: each input transfer is one typed byte; '[' homes the cursor, ']' sends it
// to the end, '<' erases the character before it, a newline reads the line out (one result
// per character, then a newline result with out_last set and out_dropped telling whether an
// insert was lost to a full pool) and clears the line; any other byte is inserted before the
// cursor. The line lives in a doubly linked list in link rams with one write port and a
// registered read, so each edit is a short chain of dependent read and write steps: end and
// an insert into a full pool are handled in the idle state, backspace at line start stops
// after its read, and a newline also waits whenever the result side stalls. After reset a
// one-cycle clearing pass resets the head links, during which in_ready stays low.
// depends on cleb_pkg, cleb_ctrl and cleb_dpath
`timescale 1ns / 1ps
`default_nettype none

module cursor_line_edit_buffer #(
  parameter int POOL_SLOTS = cleb_pkg::POOL_SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cleb_pkg::BYTE_W-1:0] in_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [cleb_pkg::BYTE_W-1:0] out_byte,
  output logic                             out_last,
  output logic                             out_dropped
);
  import cleb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cleb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cleb_dpath #(.POOL_SLOTS(POOL_SLOTS)) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_byte),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_dropped (out_dropped),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
